@@ rtl/core/dsi_pkg.sv @@
// Shared constants and types for the decimal text to integer converter.
package dsi_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 33;
  localparam int unsigned WIDTH_W = 3;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BYTES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_MODE = 1'd1;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 3'd4;

  typedef struct packed {
    logic [WIDTH_W-1:0] width_bytes;
    logic               unsigned_mode;
  } cfg_t;

  typedef struct packed {
    logic               err;
    logic [VALUE_W-1:0] value;
  } result_t;

endpackage

@@ rtl/core/dsi_range.sv @@
// Range check of the finished magnitude against the configured width and sign mode.
module dsi_range
  import dsi_pkg::*;
#(
  parameter int unsigned ACC_BITS = 64
) (
  input  logic [ACC_BITS-1:0] mag,
  input  logic                negative,
  input  logic                digit_seen,
  input  logic                overflow,
  input  cfg_t                cfg,
  output result_t             result
);

  logic over_u;
  logic over_pos;
  logic over_neg;
  logic bad_width;
  logic err;
  logic [VALUE_W-1:0] mag_v;

  always_comb begin
    over_u    = 1'b0;
    over_pos  = 1'b0;
    over_neg  = 1'b0;
    bad_width = 1'b0;
    unique case (cfg.width_bytes)
      3'd1: begin
        over_u   = (mag >> 8) != '0;
        over_pos = (mag >> 7) != '0;
        over_neg = mag > (ACC_BITS'(1) << 7);
      end
      3'd2: begin
        over_u   = (mag >> 16) != '0;
        over_pos = (mag >> 15) != '0;
        over_neg = mag > (ACC_BITS'(1) << 15);
      end
      3'd3: begin
        over_u   = (mag >> 24) != '0;
        over_pos = (mag >> 23) != '0;
        over_neg = mag > (ACC_BITS'(1) << 23);
      end
      3'd4: begin
        over_u   = (mag >> 32) != '0;
        over_pos = (mag >> 31) != '0;
        over_neg = mag > (ACC_BITS'(1) << 31);
      end
      default: bad_width = 1'b1;
    endcase
  end

  always_comb begin
    err = !digit_seen || overflow || bad_width;
    if (cfg.unsigned_mode) begin
      err = err || (negative && (mag != '0)) || over_u;
    end else begin
      err = err || (negative ? over_neg : over_pos);
    end
    mag_v = mag[VALUE_W-1:0];
    result.err   = err;
    result.value = err ? '0 : (negative ? (~mag_v + VALUE_W'(1)) : mag_v);
  end

endmodule

@@ rtl/core/decimal_string_to_int_core.sv @@
// Decimal text to integer converter: one character per cycle, result at the last one.
// The last character is registered in the hold stage, and its result then in the output register.
// Throughput: one character per cycle; the scan step is one shift-add by ten and a compare.
// A result waiting downstream stalls input only while the held character is a last one.
// Reset (synchronous, active low) clears the scan state, empties both stages,
// and sets width_bytes to 4 and unsigned_mode to 0.
module decimal_string_to_int_core
  import dsi_pkg::*;
#(
  parameter int unsigned ACC_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CHAR_W-1:0]        in_char_byte,
  input  logic                     in_last_char,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                     out_error_code
);

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  cfg_t cfg_r;

  logic              hold_valid_r;
  logic [CHAR_W-1:0] hold_char_r;
  logic              hold_last_r;

  phase_t            phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              seen_r, seen_nxt;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_err_r;

  logic                is_digit;
  logic                is_space;
  logic [ACC_BITS+3:0] prod;
  logic                take_ovf;
  logic                advance;
  logic                out_free;
  result_t             result;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = hold_valid_r && (!hold_last_r || out_free);
  assign in_stall = hold_valid_r && !advance;

  assign is_digit = (hold_char_r >= CHAR_ZERO) && (hold_char_r <= CHAR_NINE);
  assign is_space = (hold_char_r == CHAR_SPACE) ||
                    ((hold_char_r >= CHAR_TAB) && (hold_char_r <= CHAR_CR));
  assign prod = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} +
                (ACC_BITS + 4)'(hold_char_r[3:0]);
  assign take_ovf = prod[ACC_BITS+3:ACC_BITS] != '0;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r;
    unique case (phase_r)
      PH_SKIP: begin
        priority if (is_space) begin
          phase_nxt = PH_SKIP;
        end else if (hold_char_r == CHAR_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_DIGITS;
        end else if (is_digit && take_ovf) begin
          ovf_nxt   = 1'b1;
          phase_nxt = PH_STOP;
        end else if (is_digit) begin
          acc_nxt   = prod[ACC_BITS-1:0];
          seen_nxt  = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
      PH_DIGITS: begin
        priority if (is_digit && take_ovf) begin
          ovf_nxt   = 1'b1;
          phase_nxt = PH_STOP;
        end else if (is_digit) begin
          acc_nxt   = prod[ACC_BITS-1:0];
          seen_nxt  = 1'b1;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  dsi_range #(
    .ACC_BITS(ACC_BITS)
  ) u_range (
    .mag        (acc_nxt),
    .negative   (neg_nxt),
    .digit_seen (seen_nxt),
    .overflow   (ovf_nxt),
    .cfg        (cfg_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_bytes   <= WIDTH_RESET;
      cfg_r.unsigned_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_BYTES:   cfg_r.width_bytes   <= cfg_data[WIDTH_W-1:0];
        CFG_UNSIGNED_MODE: cfg_r.unsigned_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (!in_stall) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_char_r <= in_char_byte;
      hold_last_r <= in_last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else if (advance) begin
      if (hold_last_r) begin
        phase_r <= PH_SKIP;
        neg_r   <= 1'b0;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
        seen_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && hold_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_last_r) begin
      out_value_r <= result.value;
      out_err_r   <= result.err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_error_code = out_err_r;

endmodule
